FILE: hw/rtl/tma_pkg.sv
// ----------------------------------------------------------------------------
// tma_pkg
// Shared widths, command codes and sequencer types for the mesh area block.
// ----------------------------------------------------------------------------
package tma_pkg;

  localparam int unsigned SLOT_W     = 13;
  localparam int unsigned COORD_IN_W = 16;
  localparam int unsigned AREA_W     = 36;
  localparam int unsigned SUM_W      = 48;

  localparam logic [AREA_W-1:0] AREA_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_FACE = 1'b1;

  // step counter shared by the read, dot and wide product phases
  localparam int unsigned        STEP_W     = 4;
  localparam logic [STEP_W-1:0]  READ_STEPS = 4'd3;
  localparam logic [STEP_W-1:0]  DOT_STEPS  = 4'd9;
  localparam logic [STEP_W-1:0]  WIDE_STEPS = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_DOT,
    ST_WIDE,
    ST_CLAMP,
    ST_SQRT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    ACC_UU,
    ACC_VV,
    ACC_DOT
  } acc_sel_e;

endpackage

FILE: hw/rtl/tma_vstore.sv
// ----------------------------------------------------------------------------
// tma_vstore
// Vertex store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tma_vstore #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tma_mul.sv
// ----------------------------------------------------------------------------
// tma_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tma_mul #(
  parameter int unsigned W = 18
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  logic signed [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

FILE: hw/rtl/tma_isqrt.sv
// ----------------------------------------------------------------------------
// tma_isqrt
// Floor square root, restoring form, one root bit per cycle.
// ----------------------------------------------------------------------------
module tma_isqrt #(
  parameter int unsigned RW = 34
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [2*RW-1:0]   rad_i,
  output logic              done_o,
  output logic [RW-1:0]     root_o
);

  localparam int unsigned CNT_W = $clog2(RW + 1);

  logic [2*RW-1:0]  rad_q;
  logic [RW:0]      rem_q;
  logic [RW-1:0]    root_q;
  logic [CNT_W-1:0] cnt_q;

  logic [RW+2:0] rem_sh;
  logic [RW+2:0] trial;
  logic [RW+2:0] diff;
  logic          take;

  // bring down the next two radicand bits, try root*4+1
  assign rem_sh = {rem_q, rad_q[2*RW-1 -: 2]};
  assign trial  = (RW + 3)'({root_q, 2'b01});
  assign take   = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(RW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= rad_q << 2;
      rem_q  <= take ? diff[RW:0] : rem_sh[RW:0];
      root_q <= {root_q[RW-2:0], take};
    end
  end

  // high during the last iteration; root_o is final after this edge
  assign done_o = (cnt_q == CNT_W'(1));
  assign root_o = root_q;

endmodule

FILE: hw/rtl/triangle_mesh_area_accumulator_core.sv
// Load beat: no result. Face beat: one result; the next beat is not taken
// until that result has been loaded into the output register. The work per face
// is the one-bit-per-cycle square root unit plus 17 passes of the shared
// multiplier. Reset clears the sequencer, output valid and the running total;
// the vertex store is not cleared.
// ----------------------------------------------------------------------------
// triangle_mesh_area_accumulator_core
// Vertex store plus face area sequencer: edge vectors, Gram determinant on a
// shared multiplier, iterative square root, saturating mesh total.
// ----------------------------------------------------------------------------
module triangle_mesh_area_accumulator_core #(
  parameter int unsigned VERTEX_DEPTH = 4096,
  parameter int unsigned COORD_BITS   = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    command_i,
  input  logic [tma_pkg::SLOT_W-1:0]              vertex_slot_i,
  input  logic signed [tma_pkg::COORD_IN_W-1:0]   coord_x_i,
  input  logic signed [tma_pkg::COORD_IN_W-1:0]   coord_y_i,
  input  logic signed [tma_pkg::COORD_IN_W-1:0]   coord_z_i,
  input  logic [tma_pkg::SLOT_W-1:0]              corner_a_i,
  input  logic [tma_pkg::SLOT_W-1:0]              corner_b_i,
  input  logic [tma_pkg::SLOT_W-1:0]              corner_c_i,
  input  logic                                    final_face_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [tma_pkg::AREA_W-1:0]              face_area_o,
  output logic [tma_pkg::SUM_W-1:0]               mesh_total_o,
  output logic                                    total_valid_o
);

  localparam int unsigned AW = $clog2(VERTEX_DEPTH);
  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned VW = 3 * CW;
  localparam int unsigned DW = CW + 1;          // edge component
  localparam int unsigned HW = CW + 1;          // half of a wide operand
  localparam int unsigned SW = 2 * HW;          // |u|^2, |v|^2, |u.v|
  localparam int unsigned MW = HW + 1;          // multiplier operand
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned QW = 2 * SW;          // determinant
  localparam int unsigned XW = (SW > tma_pkg::AREA_W) ? SW : tma_pkg::AREA_W;

  // ---------------------------------------------------------------- control
  tma_pkg::state_e state_q, state_d;
  logic [tma_pkg::STEP_W-1:0] step_q;

  logic in_acc, mem_we, mem_re, mul_en, sq_start, sq_done, out_load;
  logic slot_ok;

  logic [tma_pkg::SLOT_W-1:0] corner_in [3];
  logic [AW-1:0]              corner_idx_q [3];
  logic [2:0]                 cvalid_q;
  logic                       fin_q;

  assign in_ready_o = (state_q == tma_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign corner_in[0] = corner_a_i;
  assign corner_in[1] = corner_b_i;
  assign corner_in[2] = corner_c_i;

  assign slot_ok = (vertex_slot_i != '0) && (32'(vertex_slot_i) <= 32'(VERTEX_DEPTH));
  assign mem_we  = in_acc && (command_i == tma_pkg::CMD_LOAD) && slot_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tma_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= (state_d != state_q) ? '0 : step_q + 1'b1;
    end
  end

  always_comb begin
    state_d  = state_q;
    mem_re   = 1'b0;
    mul_en   = 1'b0;
    sq_start = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      tma_pkg::ST_IDLE: begin
        if (in_acc && (command_i == tma_pkg::CMD_FACE)) state_d = tma_pkg::ST_READ;
      end
      tma_pkg::ST_READ: begin
        mem_re = (step_q < tma_pkg::READ_STEPS);
        if (step_q == tma_pkg::READ_STEPS) state_d = tma_pkg::ST_DIFF;
      end
      tma_pkg::ST_DIFF: begin
        state_d = tma_pkg::ST_DOT;
      end
      tma_pkg::ST_DOT: begin
        mul_en = (step_q < tma_pkg::DOT_STEPS);
        if (step_q == tma_pkg::DOT_STEPS) state_d = tma_pkg::ST_WIDE;
      end
      tma_pkg::ST_WIDE: begin
        mul_en = (step_q < tma_pkg::WIDE_STEPS);
        if (step_q == tma_pkg::WIDE_STEPS) state_d = tma_pkg::ST_CLAMP;
      end
      tma_pkg::ST_CLAMP: begin
        sq_start = 1'b1;
        state_d  = tma_pkg::ST_SQRT;
      end
      tma_pkg::ST_SQRT: begin
        if (sq_done) state_d = tma_pkg::ST_DONE;
      end
      tma_pkg::ST_DONE: begin
        if (!out_valid_o || out_ready_i) begin
          out_load = 1'b1;
          state_d  = tma_pkg::ST_IDLE;
        end
      end
      default: state_d = tma_pkg::ST_IDLE;
    endcase
  end

  // latch the face; out-of-range corners read as the origin
  always_ff @(posedge clk_i) begin
    if (in_acc && (command_i == tma_pkg::CMD_FACE)) begin
      for (int k = 0; k < 3; k++) begin
        corner_idx_q[k] <= AW'(corner_in[k] - 1'b1);
        cvalid_q[k]     <= (corner_in[k] != '0) &&
                           (32'(corner_in[k]) <= 32'(VERTEX_DEPTH));
      end
      fin_q <= final_face_i;
    end
  end

  // ---------------------------------------------------------------- store
  logic [VW-1:0] wdata, rdata;
  logic [AW-1:0] raddr;

  assign wdata = {CW'(coord_z_i), CW'(coord_y_i), CW'(coord_x_i)};

  always_comb begin
    unique case (step_q[1:0])
      2'd1:    raddr = corner_idx_q[1];
      2'd2:    raddr = corner_idx_q[2];
      default: raddr = corner_idx_q[0];
    endcase
  end

  tma_vstore #(
    .DEPTH (VERTEX_DEPTH),
    .WIDTH (VW)
  ) u_vstore (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(vertex_slot_i - 1'b1)),
    .wdata_i (wdata),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------------- vertices and edges
  logic signed [CW-1:0] vtx_q [3][3];
  logic signed [DW-1:0] u_q [3];
  logic signed [DW-1:0] v_q [3];
  logic [1:0]           cap_k;

  assign cap_k = step_q[1:0] - 2'd1;

  always_ff @(posedge clk_i) begin
    if (state_q == tma_pkg::ST_READ && step_q != '0) begin
      for (int j = 0; j < 3; j++) begin
        vtx_q[cap_k][j] <= cvalid_q[cap_k] ? rdata[j*CW +: CW] : '0;
      end
    end
    if (state_q == tma_pkg::ST_DIFF) begin
      for (int j = 0; j < 3; j++) begin
        u_q[j] <= DW'(vtx_q[1][j]) - DW'(vtx_q[0][j]);
        v_q[j] <= DW'(vtx_q[2][j]) - DW'(vtx_q[0][j]);
      end
    end
  end

  // ---------------------------------------------------------------- shared multiplier
  tma_pkg::acc_sel_e    dot_kind, kind_q;
  logic [1:0]           dot_c;
  logic signed [DW-1:0] dot_a, dot_b;

  always_comb begin
    unique case (step_q)
      4'd0:    begin dot_c = 2'd0; dot_kind = tma_pkg::ACC_UU;  end
      4'd1:    begin dot_c = 2'd0; dot_kind = tma_pkg::ACC_VV;  end
      4'd2:    begin dot_c = 2'd0; dot_kind = tma_pkg::ACC_DOT; end
      4'd3:    begin dot_c = 2'd1; dot_kind = tma_pkg::ACC_UU;  end
      4'd4:    begin dot_c = 2'd1; dot_kind = tma_pkg::ACC_VV;  end
      4'd5:    begin dot_c = 2'd1; dot_kind = tma_pkg::ACC_DOT; end
      4'd6:    begin dot_c = 2'd2; dot_kind = tma_pkg::ACC_UU;  end
      4'd7:    begin dot_c = 2'd2; dot_kind = tma_pkg::ACC_VV;  end
      4'd8:    begin dot_c = 2'd2; dot_kind = tma_pkg::ACC_DOT; end
      default: begin dot_c = 2'd0; dot_kind = tma_pkg::ACC_UU;  end
    endcase
  end

  assign dot_a = (dot_kind == tma_pkg::ACC_VV) ? v_q[dot_c] : u_q[dot_c];
  assign dot_b = (dot_kind == tma_pkg::ACC_UU) ? u_q[dot_c] : v_q[dot_c];

  logic signed [SW:0]   acc_uu_q, acc_vv_q, acc_dot_q;
  logic [SW-1:0]        dm_q;
  logic [SW-1:0]        wa_src, wb_src;
  logic [HW-1:0]        wa_half, wb_half;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  // wide phase: steps 0-3 add uu*vv, steps 4-7 subtract dot^2, by halves
  assign wa_src  = step_q[2] ? dm_q : acc_uu_q[SW-1:0];
  assign wb_src  = step_q[2] ? dm_q : acc_vv_q[SW-1:0];
  assign wa_half = step_q[1] ? wa_src[SW-1:HW] : wa_src[HW-1:0];
  assign wb_half = step_q[0] ? wb_src[SW-1:HW] : wb_src[HW-1:0];

  assign mul_a = (state_q == tma_pkg::ST_WIDE) ? signed'({1'b0, wa_half}) : MW'(dot_a);
  assign mul_b = (state_q == tma_pkg::ST_WIDE) ? signed'({1'b0, wb_half}) : MW'(dot_b);

  tma_mul #(
    .W (MW)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // ---------------------------------------------------------------- accumulation
  logic                 accp_q;
  logic                 wsub_q;
  logic [1:0]           wsh_q;
  logic signed [QW:0]   wacc_q;
  logic signed [QW:0]   prod_ext, wadd;
  logic signed [SW:0]   prod_sw;

  assign prod_sw  = (SW + 1)'(prod);
  assign prod_ext = (QW + 1)'(prod);

  always_comb begin
    unique case (wsh_q)
      2'd1:    wadd = prod_ext << HW;
      2'd2:    wadd = prod_ext << SW;
      default: wadd = prod_ext;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accp_q <= 1'b0;
    end else begin
      accp_q <= mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= dot_kind;
    wsub_q <= step_q[2];
    wsh_q  <= {1'b0, step_q[1]} + {1'b0, step_q[0]};

    if (state_q == tma_pkg::ST_DIFF) begin
      acc_uu_q  <= '0;
      acc_vv_q  <= '0;
      acc_dot_q <= '0;
      wacc_q    <= '0;
    end

    if (accp_q && state_q == tma_pkg::ST_DOT) begin
      unique case (kind_q)
        tma_pkg::ACC_UU:  acc_uu_q  <= acc_uu_q + prod_sw;
        tma_pkg::ACC_VV:  acc_vv_q  <= acc_vv_q + prod_sw;
        tma_pkg::ACC_DOT: acc_dot_q <= acc_dot_q + prod_sw;
        default:          acc_uu_q  <= acc_uu_q;
      endcase
    end

    // dot magnitude is needed from wide step 4 on
    if (state_q == tma_pkg::ST_WIDE && step_q == '0) begin
      dm_q <= acc_dot_q[SW] ? SW'(-acc_dot_q) : acc_dot_q[SW-1:0];
    end

    if (accp_q && state_q == tma_pkg::ST_WIDE) begin
      wacc_q <= wsub_q ? (wacc_q - wadd) : (wacc_q + wadd);
    end
  end

  // ---------------------------------------------------------------- square root
  logic [QW-1:0] rad;
  logic [SW-1:0] sq_root;

  assign rad = wacc_q[QW] ? '0 : wacc_q[QW-1:0];

  tma_isqrt #(
    .RW (SW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // ---------------------------------------------------------------- result
  logic [XW-1:0]               root_x;
  logic [tma_pkg::AREA_W-1:0]  area;
  logic [tma_pkg::SUM_W:0]     sum_ext;
  logic [tma_pkg::SUM_W-1:0]   sum_new;
  logic [tma_pkg::SUM_W-1:0]   sum_q;

  logic                        out_valid_q;
  logic [tma_pkg::AREA_W-1:0]  face_area_q;
  logic [tma_pkg::SUM_W-1:0]   mesh_total_q;
  logic                        total_valid_q;

  assign root_x  = XW'(sq_root);
  assign area    = (root_x > XW'(tma_pkg::AREA_MAX)) ? tma_pkg::AREA_MAX
                                                     : root_x[tma_pkg::AREA_W-1:0];
  assign sum_ext = {1'b0, sum_q} + (tma_pkg::SUM_W + 1)'(area);
  assign sum_new = sum_ext[tma_pkg::SUM_W] ? tma_pkg::SUM_MAX : sum_ext[tma_pkg::SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        sum_q       <= fin_q ? '0 : sum_new;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      face_area_q   <= area;
      mesh_total_q  <= fin_q ? sum_new : '0;
      total_valid_q <= fin_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign face_area_o   = face_area_q;
  assign mesh_total_o  = mesh_total_q;
  assign total_valid_o = total_valid_q;

`ifndef ASSERT_OFF
  a_face_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && command_i == tma_pkg::CMD_FACE) |=> (state_q == tma_pkg::ST_READ))
    else $error("face beat did not start the vertex reads");

  a_root_only_in_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == tma_pkg::ST_SQRT))
    else $error("square root finished outside its wait state");

  a_total_only_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !total_valid_o) |-> (mesh_total_o == '0))
    else $error("mesh total shown on a non-final beat");

  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && fin_q) |=> (sum_q == '0))
    else $error("running total not cleared after the final face");
`endif

endmodule
